>>> rtl/u8d_pkg.sv
// u8d_pkg: types, constants and the lead-byte decode function shared by
// the utf-8 stream decoder modules; depends on nothing
package u8d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] NONCHAR_FE = 21'h00FFFE;
  localparam logic [20:0] NONCHAR_FF = 21'h00FFFF;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] E0_LO    = 8'hA0;
  localparam logic [7:0] ED_HI    = 8'h9F;
  localparam logic [7:0] F0_LO    = 8'h90;
  localparam logic [7:0] F4_HI    = 8'h8F;
  localparam logic [7:0] LEAD_C0  = 8'hC0;
  localparam logic [7:0] LEAD_C2  = 8'hC2;
  localparam logic [7:0] LEAD_E0  = 8'hE0;
  localparam logic [7:0] LEAD_ED  = 8'hED;
  localparam logic [7:0] LEAD_F0  = 8'hF0;
  localparam logic [7:0] LEAD_F4  = 8'hF4;
  localparam logic [7:0] LEAD_F8  = 8'hF8;
  localparam logic [7:0] LEAD_FC  = 8'hFC;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        was_replaced;
    logic        end_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    MODE_LEAD  = 5'b00001,
    MODE_TWO   = 5'b00010,
    MODE_THREE = 5'b00100,
    MODE_FOUR  = 5'b01000,
    MODE_SKIP  = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  rem;
    logic [20:0] acc;
    logic        bad;
    logic [7:0]  lo;
    logic [7:0]  hi;
  } dec_state_t;

  localparam dec_state_t STATE_CLEAR = '{
    mode: MODE_LEAD, rem: 3'd0, acc: 21'd0, bad: 1'b0, lo: CONT_LO, hi: CONT_HI
  };

  typedef struct packed {
    logic [20:0] cp;
    logic        rep;
  } res_t;

  // one or two results caused by a single byte
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       valid;
    res_t       res;
    dec_state_t st;
  } lead_out_t;

  // decode a byte seen where a lead byte is expected
  function automatic lead_out_t lead_byte(input logic [7:0] b);
    lead_out_t o;
    o.valid = 1'b0;
    o.res   = '{cp: REPL_CP, rep: 1'b1};
    o.st    = STATE_CLEAR;
    priority if (b < CONT_LO) begin
      o.valid = 1'b1;
      o.res   = '{cp: {13'd0, b}, rep: 1'b0};
    end else if (b > LEAD_F4) begin
      o.st.bad  = 1'b1;
      o.st.mode = MODE_SKIP;
      o.st.rem  = (b >= LEAD_FC) ? 3'd5 : ((b >= LEAD_F8) ? 3'd4 : 3'd3);
    end else if (b >= LEAD_F0) begin
      o.st.lo   = (b == LEAD_F0) ? F0_LO : CONT_LO;
      o.st.hi   = (b == LEAD_F4) ? F4_HI : CONT_HI;
      o.st.acc  = {b[2:0], 18'd0};
      o.st.rem  = 3'd3;
      o.st.mode = MODE_FOUR;
    end else if (b >= LEAD_E0) begin
      o.st.lo   = (b == LEAD_E0) ? E0_LO : CONT_LO;
      o.st.hi   = (b == LEAD_ED) ? ED_HI : CONT_HI;
      o.st.acc  = {5'd0, b[3:0], 12'd0};
      o.st.rem  = 3'd2;
      o.st.mode = MODE_THREE;
    end else if (b >= LEAD_C2) begin
      o.st.acc  = {10'd0, b[4:0], 6'd0};
      o.st.rem  = 3'd1;
      o.st.mode = MODE_TWO;
    end else if (b >= LEAD_C0) begin
      o.st.bad  = 1'b1;
      o.st.rem  = 3'd1;
      o.st.mode = MODE_TWO;
    end else begin
      o.valid = 1'b1;
    end
    return o;
  endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: byte-wide utf-8 to code point decoder with replacement
// a byte's results pass through the entry queue and then the output register
// throughput: one byte per cycle while the queue is not full; a byte with two results holds the output two requests
// the decode state is updated as each byte is accepted, so bytes never wait on it
// reset: synchronous, active low; decoder back to lead-byte mode, queue and output empty
// depends on u8d_pkg, u8d_front, u8d_queue, u8d_back
module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  u8d_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output u8d_pkg::out_item_t out_data
);
  import u8d_pkg::*;

  // front side: a byte is taken whenever the queue has room
  logic    accept;
  logic    fr_push;
  entry_t  fr_entry;

  // queue between front and back
  entry_t  q_data;
  q_stat_t q_stat;
  logic    q_pop;

  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  // decoder state and per-byte classification
  u8d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (fr_push),
    .entry  (fr_entry)
  );

  // entries with no result (mid-sequence bytes) are never written
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (fr_entry),
    .pop     (q_pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  // back side: serialises one or two results per entry
  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // a replaced result always carries the replacement character
  a_repl_value : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.was_replaced) |-> (out_data.code_point == REPL_CP))
    else $error("replaced result without replacement code point");

  // decoded values stay within the unicode range and are never noncharacters fffe/ffff
  a_cp_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.code_point <= CP_MAX && out_data.code_point != NONCHAR_FE &&
                    out_data.code_point != NONCHAR_FF))
    else $error("code point out of range");

  // the first of two results from one byte is always the cut-sequence replacement
  a_first_of_two : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.end_of_run) |-> out_data.was_replaced)
    else $error("first of two results is not a replacement");

endmodule

>>> rtl/u8d_front.sv
// u8d_front: holds the decoder state and classifies each accepted byte
// into a queue entry of zero, one or two results; depends on u8d_pkg
module u8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  u8d_pkg::in_item_t item,
  output logic              push,
  output u8d_pkg::entry_t   entry
);
  import u8d_pkg::*;

  dec_state_t  state_r, state_nxt;
  lead_out_t   lead_res;
  logic        is_cont, cut, fin, bad_new;
  logic [2:0]  rem_dec;
  logic [20:0] cont_bits, shifted, acc_new;
  res_t        fin_res;

  always_comb begin
    lead_res  = lead_byte(item.byte_in);
    is_cont   = (item.byte_in[7:6] == 2'b10);
    rem_dec   = (state_r.rem == 3'd0) ? 3'd0 : state_r.rem - 3'd1;
    cont_bits = {15'd0, item.byte_in[5:0]};
    unique case (state_r.rem)
      3'd2:    shifted = cont_bits << 6;
      3'd3:    shifted = cont_bits << 12;
      default: shifted = cont_bits;
    endcase
    bad_new   = state_r.bad || (item.byte_in < state_r.lo) || (item.byte_in > state_r.hi);
    acc_new   = bad_new ? state_r.acc : (state_r.acc | shifted);
    state_nxt = state_r;
    cut       = 1'b0;
    fin       = 1'b0;
    fin_res   = '{cp: REPL_CP, rep: 1'b1};

    unique case (state_r.mode)
      MODE_TWO, MODE_THREE, MODE_FOUR: begin
        if (is_cont) begin
          if (rem_dec == 3'd0) begin
            fin = 1'b1;
            if (!(bad_new || acc_new == NONCHAR_FE || acc_new == NONCHAR_FF)) begin
              fin_res = '{cp: acc_new, rep: 1'b0};
            end
            state_nxt = STATE_CLEAR;
          end else begin
            state_nxt = '{mode: state_r.mode, rem: rem_dec, acc: acc_new, bad: bad_new,
                          lo: CONT_LO, hi: CONT_HI};
          end
        end else begin
          cut = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (is_cont && state_r.rem != 3'd0) begin
          if (rem_dec == 3'd0) begin
            fin       = 1'b1;
            state_nxt = STATE_CLEAR;
          end else begin
            state_nxt.rem = rem_dec;
          end
        end else begin
          cut = 1'b1;
        end
      end
      default: begin
        state_nxt = lead_res.st;
        fin       = lead_res.valid;
        fin_res   = lead_res.res;
      end
    endcase

    if (cut) begin
      // replacement for the cut sequence, then the byte again as a lead
      state_nxt    = lead_res.st;
      push         = accept;
      entry.two    = lead_res.valid;
      entry.first  = '{cp: REPL_CP, rep: 1'b1};
      entry.second = lead_res.res;
    end else begin
      push         = accept && fin;
      entry.two    = 1'b0;
      entry.first  = fin_res;
      entry.second = fin_res;
    end

    if (item.last_byte) begin
      state_nxt = STATE_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/u8d_queue.sv
// u8d_queue: short register queue of result entries between front and back
// depends on u8d_pkg
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8d_pkg::entry_t  wr_data,
  input  logic             pop,
  output u8d_pkg::entry_t  rd_data,
  output u8d_pkg::q_stat_t stat
);
  import u8d_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
    rd_data    = mem_r[rd_ptr_r];
    stat.full  = (count_r == CW'(DEPTH));
    stat.empty = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/u8d_back.sv
// u8d_back: output register that hands out the results of each entry one
// request at a time; depends on u8d_pkg
module u8d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8d_pkg::q_stat_t   q_stat,
  input  u8d_pkg::entry_t    q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output u8d_pkg::out_item_t out_data
);
  import u8d_pkg::*;

  entry_t hold_r;
  logic   valid_r, sel_r;
  logic   cur_last, take, advance;
  res_t   cur;

  always_comb begin
    cur_last = !hold_r.two || sel_r;
    take     = out_pop && valid_r;
    advance  = !valid_r || (take && cur_last);
    q_pop    = advance && !q_stat.empty;
    cur      = sel_r ? hold_r.second : hold_r.first;
    out_empty           = !valid_r;
    out_data.code_point   = cur.cp;
    out_data.was_replaced = cur.rep;
    out_data.end_of_run   = cur_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (advance) begin
      valid_r <= !q_stat.empty;
      sel_r   <= 1'b0;
    end else if (take) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold_r <= q_data;
    end
  end

endmodule
